>>> sv/color_blob_centroid_steering_core_defines.svh
// ----------------------------------------------------------------------------
// color blob centroid steering core: assertion macros
// concurrent assertion shorthands for cbcs_checker.sv, their one user among the files
// ----------------------------------------------------------------------------
`ifndef COLOR_BLOB_CENTROID_STEERING_CORE_DEFINES_SVH
`define COLOR_BLOB_CENTROID_STEERING_CORE_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define CBCS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define CBCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

>>> sv/cbcs_pkg.sv
// ----------------------------------------------------------------------------
// cbcs_pkg
// shared widths, codes, reset values and types of the blob steering core
// ----------------------------------------------------------------------------
package cbcs_pkg;

  // field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SIDE_CFG_W = 12;
  localparam int unsigned MARGIN_W   = 8;
  localparam int unsigned MINP_W     = 23;
  localparam int unsigned BAND_W     = 10;
  localparam int unsigned CENT_W     = 11;
  localparam int unsigned BLOB_W     = 23;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned IN_DATA_W  = 3 * PIX_W;
  localparam int unsigned OUT_DATA_W = 48;

  // default largest frame side
  localparam int unsigned MAX_SIDE_DEF = 2048;

  // frame record queue depth
  localparam int unsigned QDEPTH = 2;

  // register reset values
  localparam logic [SIDE_CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [SIDE_CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [MARGIN_W-1:0]   COLOR_MARGIN_RST = 8'd100;
  localparam logic [MINP_W-1:0]     MIN_PIXELS_RST   = 23'd300;
  localparam logic [BAND_W-1:0]     CENTER_BAND_RST  = 10'd15;
  localparam logic [CENT_W-1:0]     PREV_X_RST       = 11'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COLOR_MARGIN = 3'd2,
    CFG_MIN_PIXELS   = 3'd3,
    CFG_CENTER_BAND  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_FWD   = 3'd1,
    CMD_LFWD  = 3'd2,
    CMD_RFWD  = 3'd3,
    CMD_LEFT  = 3'd4,
    CMD_RIGHT = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_STEER,
    BK_EMIT_FIRST,
    BK_EMIT_SECOND
  } back_state_e;

  typedef struct packed {
    logic [SIDE_CFG_W-1:0] frame_width;
    logic [SIDE_CFG_W-1:0] frame_height;
    logic [MARGIN_W-1:0]   color_margin;
  } front_cfg_t;

  typedef struct packed {
    logic [SIDE_CFG_W-1:0] frame_width;
    logic [MINP_W-1:0]     min_pixels;
    logic [BAND_W-1:0]     center_band;
  } steer_cfg_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [BLOB_W-1:0] blob_pixels;
    logic [CENT_W-1:0] centroid_y;
    logic [CENT_W-1:0] centroid_x;
    cmd_e              command;
  } result_t;

  typedef struct packed {
    logic push;
    logic full;
  } rec_ctl_t;

endpackage

>>> sv/cbcs_front.sv
// ----------------------------------------------------------------------------
// cbcs_front
// pixel side: colour test, raster position and exact blob sums per frame
// ----------------------------------------------------------------------------
module cbcs_front import cbcs_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF,
  localparam int unsigned POS_W = $clog2(MAX_SIDE),
  localparam int unsigned CNT_W = $clog2(MAX_SIDE * MAX_SIDE + 1),
  localparam int unsigned SUM_W = CNT_W + POS_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  front_cfg_t       cfg_i,
  input  logic             pix_valid_i,
  output logic             pix_ready_o,
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  output rec_ctl_t         rec_ctl_o,
  input  logic             rec_full_i,
  output logic [SUM_W-1:0] rec_sum_cols_o,
  output logic [SUM_W-1:0] rec_sum_rows_o,
  output logic [CNT_W-1:0] rec_count_o
);

  localparam int unsigned CMP_W = SIDE_CFG_W + 1;
  localparam logic [CMP_W-1:0] MAX_SIDE_C = CMP_W'(MAX_SIDE);

  logic [POS_W-1:0] col_q, col_d, row_q, row_d;
  logic [SUM_W-1:0] sum_cols_q, sum_cols_d, sum_rows_q, sum_rows_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic             hit, accept, col_last, row_last, frame_end;
  logic [CMP_W-1:0] w_eff, h_eff;
  logic [SUM_W-1:0] sum_cols_inc, sum_rows_inc;
  logic [CNT_W-1:0] count_inc;

  // clamp a side setting to 1..MAX_SIDE
  function automatic logic [CMP_W-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve == '0) begin
      return CMP_W'(1);
    end else if (ve > MAX_SIDE_C) begin
      return MAX_SIDE_C;
    end else begin
      return ve;
    end
  endfunction

  always_comb begin
    hit = ({1'b0, red_i} >= ({1'b0, blue_i} + {1'b0, cfg_i.color_margin})) &&
          ({1'b0, red_i} >= ({1'b0, green_i} + {1'b0, cfg_i.color_margin}));
    accept    = pix_valid_i && !rec_full_i;
    w_eff     = clamp_side(cfg_i.frame_width);
    h_eff     = clamp_side(cfg_i.frame_height);
    col_last  = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
    row_last  = (CMP_W'(row_q) + CMP_W'(1)) >= h_eff;
    frame_end = col_last && row_last;

    sum_cols_inc = sum_cols_q + (hit ? SUM_W'(col_q) : '0);
    sum_rows_inc = sum_rows_q + (hit ? SUM_W'(row_q) : '0);
    count_inc    = count_q + CNT_W'(hit);

    col_d      = col_q;
    row_d      = row_q;
    sum_cols_d = sum_cols_q;
    sum_rows_d = sum_rows_q;
    count_d    = count_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + POS_W'(1);
      end else begin
        col_d = col_q + POS_W'(1);
      end
      // frame totals go to the queue, counters restart
      sum_cols_d = frame_end ? '0 : sum_cols_inc;
      sum_rows_d = frame_end ? '0 : sum_rows_inc;
      count_d    = frame_end ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      sum_cols_q <= '0;
      sum_rows_q <= '0;
      count_q    <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      sum_cols_q <= sum_cols_d;
      sum_rows_q <= sum_rows_d;
      count_q    <= count_d;
    end
  end

  assign pix_ready_o    = !rec_full_i;
  assign rec_ctl_o.push = accept && frame_end;
  assign rec_ctl_o.full = rec_full_i;
  assign rec_sum_cols_o = sum_cols_inc;
  assign rec_sum_rows_o = sum_rows_inc;
  assign rec_count_o    = count_inc;

endmodule

>>> sv/cbcs_fifo.sv
// ----------------------------------------------------------------------------
// cbcs_fifo
// short queue of frame records between pixel side and steering side
// ----------------------------------------------------------------------------
module cbcs_fifo import cbcs_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0]  mem_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q + FILL_W'(do_push) - FILL_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign full_o  = (fill_q == FILL_W'(QDEPTH));
  assign valid_o = (fill_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

endmodule

>>> sv/cbcs_div.sv
// ----------------------------------------------------------------------------
// cbcs_div
// restoring divider, one quotient bit per cycle, quotient known to fit QUO_W
// ----------------------------------------------------------------------------
module cbcs_div import cbcs_pkg::*; #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 23,
  parameter int unsigned QUO_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0]  rem_q, den_q;
  logic [QUO_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              run_q, done_q, ge;

  assign ge = (rem_q >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= STEP_W'(QUO_W);
      end else if (run_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= NUM_W'(den_i) << (QUO_W - 1);
      quo_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - den_q;
      end
      den_q <= den_q >> 1;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> sv/cbcs_back.sv
// ----------------------------------------------------------------------------
// cbcs_back
// frame side: centroid division, steering decision and result register
// ----------------------------------------------------------------------------
module cbcs_back import cbcs_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF,
  localparam int unsigned POS_W = $clog2(MAX_SIDE),
  localparam int unsigned CNT_W = $clog2(MAX_SIDE * MAX_SIDE + 1),
  localparam int unsigned SUM_W = CNT_W + POS_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  steer_cfg_t       cfg_i,
  input  logic             rec_valid_i,
  output logic             rec_pop_o,
  input  logic [SUM_W-1:0] rec_sum_cols_i,
  input  logic [SUM_W-1:0] rec_sum_rows_i,
  input  logic [CNT_W-1:0] rec_count_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_data_o,
  output logic             res_last_o
);

  localparam int unsigned SG_W  = ((POS_W > SIDE_CFG_W) ? POS_W : SIDE_CFG_W) + 2;
  localparam int unsigned MIN_W = (CNT_W > MINP_W) ? CNT_W : MINP_W;

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q;
  logic [POS_W-1:0]  quo_x, quo_y, cx_full, cy_full;
  logic              done_x, done_y;
  logic              div_start, steer_load, emit_first, emit_second, out_free;

  logic [CENT_W-1:0] cx_q, cy_q, prev_x_q;
  cmd_e              first_cmd_q, steer_cmd;
  logic              two_q, steer_two, turn_right_q, steer_set_turn, steer_turn;

  logic signed [SG_W-1:0] x_s, half_s, band_s, prev_s, lo_s, hi_s;
  logic                   lost;

  result_t res_q;
  logic    res_valid_q, res_last_q;

  // two dividers run side by side on the popped frame record
  cbcs_div #(.NUM_W(SUM_W), .DEN_W(CNT_W), .QUO_W(POS_W)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rec_sum_cols_i),
    .den_i   (rec_count_i),
    .done_o  (done_x),
    .quo_o   (quo_x)
  );

  cbcs_div #(.NUM_W(SUM_W), .DEN_W(CNT_W), .QUO_W(POS_W)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rec_sum_rows_i),
    .den_i   (rec_count_i),
    .done_o  (done_y),
    .quo_o   (quo_y)
  );

  assign out_free = !res_valid_q || res_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:        if (rec_valid_i) state_d = BK_DIV;
      BK_DIV:         if (done_x && done_y) state_d = BK_STEER;
      BK_STEER:       state_d = BK_EMIT_FIRST;
      BK_EMIT_FIRST:  if (out_free) state_d = two_q ? BK_EMIT_SECOND : BK_IDLE;
      BK_EMIT_SECOND: if (out_free) state_d = BK_IDLE;
      default:        state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    rec_pop_o   = 1'b0;
    div_start   = 1'b0;
    steer_load  = 1'b0;
    emit_first  = 1'b0;
    emit_second = 1'b0;
    case (state_q)
      BK_IDLE: begin
        rec_pop_o = rec_valid_i;
        div_start = rec_valid_i;
      end
      BK_STEER:       steer_load  = 1'b1;
      BK_EMIT_FIRST:  emit_first  = out_free;
      BK_EMIT_SECOND: emit_second = out_free;
      default: ;
    endcase
  end

  // steering rules on the fresh centroid
  always_comb begin
    cx_full = (cnt_q == '0) ? '0 : quo_x;
    cy_full = (cnt_q == '0) ? '0 : quo_y;
    x_s     = $signed(SG_W'(cx_full));
    half_s  = $signed(SG_W'(cfg_i.frame_width >> 1));
    band_s  = $signed(SG_W'(cfg_i.center_band));
    prev_s  = $signed(SG_W'(prev_x_q));
    lo_s    = half_s - band_s;
    hi_s    = half_s + band_s;
    lost    = MIN_W'(cnt_q) < MIN_W'(cfg_i.min_pixels);

    steer_two      = 1'b0;
    steer_set_turn = 1'b0;
    steer_turn     = turn_right_q;
    if (lost) begin
      steer_cmd = turn_right_q ? CMD_RIGHT : CMD_LEFT;
    end else if (x_s < hi_s && x_s > lo_s) begin
      steer_cmd = CMD_FWD;
    end else if (x_s < lo_s && (x_s - prev_s) > band_s) begin
      steer_cmd = CMD_LFWD;
    end else if (x_s > hi_s && (prev_s - x_s) > band_s) begin
      steer_cmd = CMD_RFWD;
    end else if (x_s < lo_s) begin
      steer_cmd      = CMD_LEFT;
      steer_two      = 1'b1;
      steer_set_turn = 1'b1;
      steer_turn     = 1'b0;
    end else if (x_s > hi_s) begin
      steer_cmd      = CMD_RIGHT;
      steer_two      = 1'b1;
      steer_set_turn = 1'b1;
      steer_turn     = 1'b1;
    end else begin
      // centroid sits exactly on a band edge
      steer_cmd = CMD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      prev_x_q     <= PREV_X_RST;
      turn_right_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (steer_load) begin
        prev_x_q <= CENT_W'(cx_full);
        if (steer_set_turn) begin
          turn_right_q <= steer_turn;
        end
      end
      if (emit_first || emit_second) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      cnt_q <= rec_count_i;
    end
    if (steer_load) begin
      cx_q        <= CENT_W'(cx_full);
      cy_q        <= CENT_W'(cy_full);
      first_cmd_q <= steer_cmd;
      two_q       <= steer_two;
    end
    if (emit_first || emit_second) begin
      res_q.command     <= emit_first ? first_cmd_q : CMD_FWD;
      res_q.centroid_x  <= cx_q;
      res_q.centroid_y  <= cy_q;
      res_q.blob_pixels <= BLOB_W'(cnt_q);
      res_last_q        <= emit_second || !two_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;
  assign res_last_o  = res_last_q;

endmodule

>>> sv/color_blob_centroid_steering_core.sv
// ----------------------------------------------------------------------------
// color_blob_centroid_steering_core
// red blob tracker: per-frame centroid of red pixels and steering commands
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one item per pixel, and are accepted one per
// cycle as long as the two-entry frame queue has room. A pixel counts as blob
// when red is at least color_margin above both green and blue. At the last
// pixel of a frame the exact column sum, row sum and blob count go into the
// queue; the back end then divides (one quotient bit per cycle in two
// parallel restoring dividers), makes the steering decision and
// emits one or two result items through the output register, which
// holds an item while m_axis_tready is low. The pixel side keeps
// running meanwhile and only stalls when two finished
// frames are still waiting. Results: turn toward the last turn when fewer
// than min_pixels blob pixels were seen, forward inside the center band,
// left/right forward when off center but already moving back, otherwise a
// turn item followed by a forward item; a centroid exactly on a band edge
// gives command none. tlast marks the final item of each frame. Registers
// (index: reset) are frame_width 0: 640, frame_height 1: 480,
// color_margin 2: 100, min_pixels 3: 300, center_band 4: 15; sides are
// clamped to 1..MAX_SIDE. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module color_blob_centroid_steering_core import cbcs_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // red, green, blue
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // command, centroid_x, centroid_y, blob_pixels
  output logic                  m_axis_tlast,   // last_of_frame
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned POS_W = $clog2(MAX_SIDE);
  localparam int unsigned CNT_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int unsigned SUM_W = CNT_W + POS_W;
  localparam int unsigned REC_W = 2 * SUM_W + CNT_W;

  // configuration registers
  logic [SIDE_CFG_W-1:0] frame_width_q, frame_height_q;
  logic [MARGIN_W-1:0]   color_margin_q;
  logic [MINP_W-1:0]     min_pixels_q;
  logic [BAND_W-1:0]     center_band_q;

  front_cfg_t front_cfg;
  steer_cfg_t steer_cfg;

  // frame record path
  rec_ctl_t         rec_ctl;
  logic             rec_full, rec_valid, rec_pop;
  logic [SUM_W-1:0] fr_sum_cols, fr_sum_rows, bk_sum_cols, bk_sum_rows;
  logic [CNT_W-1:0] fr_count, bk_count;
  logic [REC_W-1:0] rec_rdata;

  result_t res_data;

  // register file, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      color_margin_q <= COLOR_MARGIN_RST;
      min_pixels_q   <= MIN_PIXELS_RST;
      center_band_q  <= CENTER_BAND_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[SIDE_CFG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[SIDE_CFG_W-1:0];
        CFG_COLOR_MARGIN: color_margin_q <= cfg_data_i[MARGIN_W-1:0];
        CFG_MIN_PIXELS:   min_pixels_q   <= cfg_data_i[MINP_W-1:0];
        CFG_CENTER_BAND:  center_band_q  <= cfg_data_i[BAND_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign front_cfg.frame_width  = frame_width_q;
  assign front_cfg.frame_height = frame_height_q;
  assign front_cfg.color_margin = color_margin_q;
  assign steer_cfg.frame_width  = frame_width_q;
  assign steer_cfg.min_pixels   = min_pixels_q;
  assign steer_cfg.center_band  = center_band_q;

  // pixel side
  cbcs_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (front_cfg),
    .pix_valid_i    (s_axis_tvalid),
    .pix_ready_o    (s_axis_tready),
    .red_i          (s_axis_tdata[PIX_W-1:0]),
    .green_i        (s_axis_tdata[2*PIX_W-1:PIX_W]),
    .blue_i         (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
    .rec_ctl_o      (rec_ctl),
    .rec_full_i     (rec_full),
    .rec_sum_cols_o (fr_sum_cols),
    .rec_sum_rows_o (fr_sum_rows),
    .rec_count_o    (fr_count)
  );

  // frame record queue
  cbcs_fifo #(.WIDTH(REC_W)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_ctl.push),
    .wdata_i ({fr_sum_cols, fr_sum_rows, fr_count}),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .valid_o (rec_valid),
    .rdata_o (rec_rdata)
  );

  assign bk_sum_cols = rec_rdata[REC_W-1:SUM_W+CNT_W];
  assign bk_sum_rows = rec_rdata[SUM_W+CNT_W-1:CNT_W];
  assign bk_count    = rec_rdata[CNT_W-1:0];

  // steering side
  cbcs_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (steer_cfg),
    .rec_valid_i    (rec_valid),
    .rec_pop_o      (rec_pop),
    .rec_sum_cols_i (bk_sum_cols),
    .rec_sum_rows_i (bk_sum_rows),
    .rec_count_i    (bk_count),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_data_o     (res_data),
    .res_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = res_data;

endmodule

>>> sv/cbcs_checker.sv
// ----------------------------------------------------------------------------
// cbcs_checker
// port-level checks on the result stream of the blob steering core
// ----------------------------------------------------------------------------
`include "color_blob_centroid_steering_core_defines.svh"

module cbcs_checker import cbcs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // stalled result stays up
  `CBCS_ASSERT(a_res_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // stalled result does not change
  `CBCS_ASSERT(a_res_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  // only a turn item may be followed by another item of the same frame
  `CBCS_ASSERT(a_first_is_turn, m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[2:0] == CMD_LEFT) || (m_axis_tdata[2:0] == CMD_RIGHT), "non-final item is not a turn")

  // the item after a taken turn item is the closing forward of the same frame
  `CBCS_ASSERT(a_second_fwd, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast && (m_axis_tdata[2:0] == CMD_FWD) && (m_axis_tdata[47:3] == $past(m_axis_tdata[47:3])), "turn item not followed by forward item")

endmodule

bind color_blob_centroid_steering_core cbcs_checker u_cbcs_checker (.*);

>>> tb/color_blob_centroid_steering_core_test.sv
// ----------------------------------------------------------------------------
// color_blob_centroid_steering_core_test
// self-checking bench for the red blob centroid steering core
// ----------------------------------------------------------------------------
// Pixels stream in through the slave side in bursts with random gaps, and
// results are drained with a receiver that stalls in runs. A predictor built
// into the bench tracks column/row, the exact blob sums and count, and the
// steering memory (previous centroid column, last turn), queues the command
// items each frame end produces, and every result item is checked field by
// field against the oldest queued one. Directed tests walk every steering
// outcome, the clamped frame sides, register extremes and a mid-frame size
// change; a random part then runs many small frames under random settings.
// ----------------------------------------------------------------------------
module color_blob_centroid_steering_core_test;
  import cbcs_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 1200;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no item moving

  // --------------------------------------------------------------------------
  // dut hookup, every input known from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // red, green, blue
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // command, centroid_x, centroid_y, blob_pixels
  logic                  m_axis_tlast;        // last_of_frame
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  color_blob_centroid_steering_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // predictor state: registers as the block holds them, plus frame tracking
  // --------------------------------------------------------------------------
  logic [SIDE_CFG_W-1:0] cfg_width  = FRAME_WIDTH_RST;
  logic [SIDE_CFG_W-1:0] cfg_height = FRAME_HEIGHT_RST;
  logic [MARGIN_W-1:0]   cfg_margin = COLOR_MARGIN_RST;
  logic [MINP_W-1:0]     cfg_min    = MIN_PIXELS_RST;
  logic [BAND_W-1:0]     cfg_band   = CENTER_BAND_RST;

  int unsigned     col_at       = 0;
  int unsigned     row_at       = 0;
  longint unsigned col_sum      = 0;
  longint unsigned row_sum      = 0;
  longint unsigned red_count    = 0;
  logic [CENT_W-1:0] last_x     = PREV_X_RST;
  bit              turned_right = 1'b0;
  bit              frame_done   = 1'b0;  // last tracked pixel closed a frame

  typedef struct {
    cmd_e              command;
    logic [CENT_W-1:0] cx;
    logic [CENT_W-1:0] cy;
    logic [BLOB_W-1:0] pixels;
    logic              fin;
  } steer_item_t;

  steer_item_t steer_q[$];  // command items still owed by the block

  int unsigned mismatches   = 0;
  int unsigned pixel_total  = 0;
  int unsigned burst_left   = 0;
  int unsigned rdy_hold     = 0;
  int unsigned quiet_cycles = 0;
  bit          pace_on      = 1'b0;  // random gaps and stalls on both sides

  function automatic int unsigned side_clamp(logic [SIDE_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return v;
  endfunction

  function automatic void owe_item(cmd_e c, logic [CENT_W-1:0] cx, logic [CENT_W-1:0] cy,
                                   logic [BLOB_W-1:0] n, logic fin);
    steer_item_t it;
    it.command = c;
    it.cx      = cx;
    it.cy      = cy;
    it.pixels  = n;
    it.fin     = fin;
    steer_q.push_back(it);
  endfunction

  // one accepted pixel: accumulate, step the raster, steer at frame end
  function automatic void track_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                      logic [PIX_W-1:0] b);
    int unsigned       w;
    int unsigned       h;
    int                x;
    int                half;
    int                band;
    int                prev;
    logic [CENT_W-1:0] cx;
    logic [CENT_W-1:0] cy;
    logic [BLOB_W-1:0] n;
    w = side_clamp(cfg_width);
    h = side_clamp(cfg_height);
    frame_done = 1'b0;
    if (int'(r) - int'(b) >= int'(cfg_margin) && int'(r) - int'(g) >= int'(cfg_margin)) begin
      col_sum += col_at;
      row_sum += row_at;
      red_count++;
    end
    // a shrunk size ends the line or frame at once
    if (col_at + 1 >= w) begin
      col_at = 0;
      if (row_at + 1 >= h) begin
        row_at = 0;
        frame_done = 1'b1;
      end else begin
        row_at++;
      end
    end else begin
      col_at++;
    end
    if (!frame_done) return;

    cx = '0;
    cy = '0;
    if (red_count != 0) begin
      cx = CENT_W'(col_sum / red_count);
      cy = CENT_W'(row_sum / red_count);
    end
    n    = BLOB_W'(red_count);
    x    = int'(cx);
    half = int'(cfg_width) / 2;  // raw register, not the clamped side
    band = int'(cfg_band);
    prev = int'(last_x);

    if (red_count < cfg_min) begin
      // target lost: repeat the last turn
      owe_item(turned_right ? CMD_RIGHT : CMD_LEFT, cx, cy, n, 1'b1);
    end else if (x < half + band && x > half - band) begin
      owe_item(CMD_FWD, cx, cy, n, 1'b1);
    end else if (x < half - band && x - prev > band) begin
      owe_item(CMD_LFWD, cx, cy, n, 1'b1);
    end else if (x > half + band && prev - x > band) begin
      owe_item(CMD_RFWD, cx, cy, n, 1'b1);
    end else if (x < half - band) begin
      owe_item(CMD_LEFT, cx, cy, n, 1'b0);
      owe_item(CMD_FWD, cx, cy, n, 1'b1);
      turned_right = 1'b0;
    end else if (x > half + band) begin
      owe_item(CMD_RIGHT, cx, cy, n, 1'b0);
      owe_item(CMD_FWD, cx, cy, n, 1'b1);
      turned_right = 1'b1;
    end else begin
      // centroid sits exactly on a band edge
      owe_item(CMD_NONE, cx, cy, n, 1'b1);
    end
    last_x    = cx;
    col_sum   = 0;
    row_sum   = 0;
    red_count = 0;
  endfunction

  // --------------------------------------------------------------------------
  // pixel sender: bursts of random length, random gaps between them
  // --------------------------------------------------------------------------
  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(48, 1);
      gap = pace_on ? $urandom_range(6, 0) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    // valid stays up from the previous item, so only one update per step
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    pixel_total++;
    track_pixel(r, g, b);
  endtask

  // red at least margin above green and blue, content otherwise random
  task automatic send_blob_pixel();
    int unsigned r;
    r = $urandom_range(255, cfg_margin);
    send_pixel(PIX_W'(r), PIX_W'($urandom_range(r - cfg_margin, 0)),
               PIX_W'($urandom_range(r - cfg_margin, 0)));
  endtask

  task automatic send_noise_pixel();
    send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
  endtask

  // rest of the current frame, blob pixels confined to columns lo..hi
  task automatic send_frame(int unsigned lo, int unsigned hi, int unsigned density);
    do begin
      if (col_at >= lo && col_at <= hi && $urandom_range(99, 0) < density) begin
        send_blob_pixel();
      end else begin
        send_noise_pixel();
      end
    end while (!frame_done);
  endtask

  // stop sending, collect every owed item, then let the back end go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // register writes, only issued while the block is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FRAME_WIDTH:  cfg_width  = val[SIDE_CFG_W-1:0];
      CFG_FRAME_HEIGHT: cfg_height = val[SIDE_CFG_W-1:0];
      CFG_COLOR_MARGIN: cfg_margin = val[MARGIN_W-1:0];
      CFG_MIN_PIXELS:   cfg_min    = val[MINP_W-1:0];
      CFG_CENTER_BAND:  cfg_band   = val[BAND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                          logic [CFG_DATA_W-1:0] margin, logic [CFG_DATA_W-1:0] minp,
                          logic [CFG_DATA_W-1:0] band);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_COLOR_MARGIN, margin);
    write_reg(CFG_MIN_PIXELS, minp);
    write_reg(CFG_CENTER_BAND, band);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: stall pattern and checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!pace_on) begin
      m_axis_tready <= 1'b1;
    end else if (rdy_hold != 0) begin
      rdy_hold--;
    end else begin
      // leaving ready gives a stall run, leaving a stall gives a ready run
      m_axis_tready <= !m_axis_tready;
      rdy_hold = m_axis_tready ? $urandom_range(10, 0) : $urandom_range(24, 0);
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    result_t     got;
    steer_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (steer_q.size() == 0) begin
        report_mismatch("result item with no frame end pending");
      end else begin
        want = steer_q.pop_front();
        if (got.command !== want.command)
          report_mismatch($sformatf("command got %0d want %0d", got.command, want.command));
        if (got.centroid_x !== want.cx)
          report_mismatch($sformatf("centroid_x got %0d want %0d", got.centroid_x, want.cx));
        if (got.centroid_y !== want.cy)
          report_mismatch($sformatf("centroid_y got %0d want %0d", got.centroid_y, want.cy));
        if (got.blob_pixels !== want.pixels)
          report_mismatch($sformatf("blob_pixels got %0d want %0d", got.blob_pixels,
                                    want.pixels));
        if (m_axis_tlast !== want.fin)
          report_mismatch($sformatf("tlast got %0b want %0b", m_axis_tlast, want.fin));
      end
    end
  end

  // watchdog: any item moving on any channel resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // 4x1 frames, at most one blob pixel placed to walk every steering outcome
  task automatic test_steering_cases();
    pace_on = 1'b1;
    set_regs(4, 1, 100, 1, 0);
    // blob at column 3 while previous_x is still the reset value: right forward
    send_pixel(0, 0, 0);     send_pixel(255, 255, 255);
    send_pixel(99, 0, 0);    send_pixel(255, 0, 0);
    // empty frame: lost, repeats the reset left turn, centroid 0
    send_pixel(0, 0, 255);   send_pixel(0, 255, 0);
    send_pixel(50, 60, 70);  send_pixel(128, 128, 128);
    // column 1, previous 0: left forward; exact margin on both channels
    send_pixel(1, 0, 0);     send_pixel(200, 100, 100);
    send_pixel(155, 56, 55); send_pixel(255, 156, 0);
    // column 0, previous 1: left then forward
    send_pixel(100, 0, 0);   send_pixel(255, 0, 156);
    send_pixel(0, 255, 255); send_pixel(255, 255, 0);
    // column 3, previous 0: right then forward
    send_pixel(127, 255, 1); send_pixel(254, 200, 3);
    send_pixel(2, 1, 254);   send_pixel(255, 1, 2);
    // column 2 with band 0: on the edge, none
    send_pixel(7, 7, 7);     send_pixel(99, 255, 0);
    send_pixel(156, 56, 0);  send_pixel(64, 0, 0);
    settle();
    set_regs(4, 1, 100, 1, 1);
    // column 2 inside the band: forward
    send_pixel(0, 0, 0);     send_pixel(0, 0, 0);
    send_pixel(255, 0, 0);   send_pixel(0, 0, 0);
    // empty again, last turn was right
    repeat (4) send_pixel(10, 20, 30);
    settle();
  endtask

  // zero sides clamped to 1, upper register bits dropped
  task automatic test_size_extremes();
    pace_on = 1'b1;
    // zero sides: every pixel is a whole frame
    set_regs(0, 0, 100, 0, 0);
    repeat (3) send_noise_pixel();
    repeat (3) send_blob_pixel();
    settle();
    set_regs(23'h7FF003, 23'h7FF002, 23'h7FFF50, 23'h7FFFFF, 23'h7FFC05);
    repeat (2) send_frame(0, 2, 100);
    settle();
  endtask

  // margin, minimum count and band at their ends
  task automatic test_register_extremes();
    logic [CFG_DATA_W-1:0] margins[4] = '{0, 255, 255, 0};
    logic [CFG_DATA_W-1:0] minps[4]   = '{0, 23'h7FFFFF, 0, 1};
    logic [CFG_DATA_W-1:0] bands[4]   = '{0, 1023, 1023, 0};
    pace_on = 1'b0;
    for (int i = 0; i < 4; i++) begin
      set_regs(6, 2, margins[i], minps[i], bands[i]);
      repeat (3) send_frame($urandom_range(5, 0), 5, 100);
      settle();
    end
  endtask

  // sides rewritten while a frame is half done
  task automatic test_midframe_resize();
    pace_on = 1'b1;
    set_regs(6, 3, 60, 1, 2);
    repeat (10) send_noise_pixel();
    settle();
    // column already past the new width: line and frame end on the next item
    set_regs(3, 2, 60, 1, 2);
    send_frame(0, 2, 70);
    send_frame(1, 1, 100);
    repeat (8) send_noise_pixel();
    settle();
    set_regs(9, 5, 60, 1, 2);
    repeat (30) send_noise_pixel();
    settle();
    // row already past the new height
    set_regs(4, 2, 60, 1, 2);
    send_frame(0, 3, 60);
    settle();
  endtask

  // phases of random settings, small frames with random blob placement
  task automatic test_random_frames();
    int unsigned start;
    int unsigned wide;
    int unsigned lo;
    int unsigned hi;
    int unsigned density;
    start = pixel_total;
    while (pixel_total - start < RANDOM_PIXELS) begin
      pace_on = ($urandom_range(3, 0) != 0);
      set_regs(($urandom_range(9, 0) == 0) ? $urandom_range(120, 25) : $urandom_range(24, 0),
               $urandom_range(4, 0),
               ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(120, 20),
               ($urandom_range(5, 0) == 0) ? $urandom_range(23'h7FFFFF, 0)
                                           : $urandom_range(4, 0),
               ($urandom_range(7, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(6, 0));
      wide = side_clamp(cfg_width);
      repeat ($urandom_range(5, 1)) begin
        lo = $urandom_range(wide - 1, 0);
        hi = $urandom_range(wide - 1, lo);
        case ($urandom_range(3, 0))
          0:       density = 0;
          1:       density = 35;
          2:       density = 75;
          default: density = 100;
        endcase
        send_frame(lo, hi, density);
      end
      // sometimes leave a broken frame behind for the next settings
      if ($urandom_range(2, 0) == 0) repeat ($urandom_range(8, 1)) send_noise_pixel();
      settle();
    end
  endtask

  initial begin : run
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_steering_cases();
    test_size_extremes();
    test_register_extremes();
    test_midframe_resize();
    test_random_frames();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
